/* rtl/thermometer_seven_segment_encoder_core_defines.svh */
// Assertion macros used by the checker file of the encoder core
`ifndef THERMOMETER_SEVEN_SEGMENT_ENCODER_CORE_DEFINES_SVH
`define THERMOMETER_SEVEN_SEGMENT_ENCODER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TSSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define TSSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tsse_pkg.sv */
// Package: shared types, constants and segment table of the encoder core
`timescale 1ns / 1ps
package tsse_pkg;

  localparam logic [15:0] SENSOR_MAX_OK = 16'd64000;
  localparam logic [6:0]  MINUS_SEG     = 7'b0000001;
  // x / 5 == (x * 52429) >> 18 for x < 2^18
  localparam logic [16:0] DIV5_MUL      = 17'd52429;
  // x / 10 == (x * 6554) >> 16 for x < 2^14
  localparam logic [12:0] DIV10_MUL     = 13'd6554;

  typedef struct packed {
    logic s0;
    logic s1;
    logic s2;
  } stage_en_t;

  // Converted value handed from the converter to the digit stages
  typedef struct packed {
    logic        err;
    logic        fahr;
    logic        neg;
    logic [10:0] mag;
  } conv_t;

  function automatic logic [6:0] seg7(input logic [3:0] d);
    logic [6:0] s;
    unique case (d)
      4'd0:    s = 7'b1111110;
      4'd1:    s = 7'b0001100;
      4'd2:    s = 7'b0110111;
      4'd3:    s = 7'b0011111;
      4'd4:    s = 7'b1001101;
      4'd5:    s = 7'b1011011;
      4'd6:    s = 7'b1111011;
      4'd7:    s = 7'b0001110;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1011111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

endpackage

/* rtl/tsse_convert.sv */
// Converter stages: raw reading to signed tenths, unit scaling, magnitude
`timescale 1ns / 1ps
module tsse_convert (
  input  logic                clk,
  input  tsse_pkg::stage_en_t en,
  input  logic [15:0]         reading,
  input  logic                fahr,
  output tsse_pkg::conv_t     conv
);

  // stage 0: range check and Celsius tenths
  logic signed [10:0] c0_r;
  logic               err0_r, fahr0_r;
  logic signed [10:0] c0_nxt;

  assign c0_nxt = $signed({1'b0, reading[15:6]}) - 11'sd500
                + $signed({10'b0, reading[5]});

  always_ff @(posedge clk) begin
    if (en.s0) begin
      c0_r    <= c0_nxt;
      err0_r  <= (reading > tsse_pkg::SENSOR_MAX_OK);
      fahr0_r <= fahr;
    end
  end

  // stage 1: 9c+1600 when Fahrenheit, then sign and magnitude
  logic signed [13:0] c_ext, n9, sel;
  logic [12:0]        na1_r, na1_nxt;
  logic               neg1_r, err1_r, fahr1_r;

  assign c_ext   = {{3{c0_r[10]}}, c0_r};
  assign n9      = (c_ext <<< 3) + c_ext + 14'sd1600;
  assign sel     = fahr0_r ? n9 : c_ext;
  assign na1_nxt = sel[13] ? 13'(-sel) : sel[12:0];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      na1_r   <= na1_nxt;
      neg1_r  <= sel[13];
      err1_r  <= err0_r;
      fahr1_r <= fahr0_r;
    end
  end

  // stage 2: divide by 5 when Fahrenheit (truncation toward zero on the magnitude)
  logic [29:0] prod5;
  logic [11:0] q5;
  logic [10:0] m2_r;
  logic        neg2_r, err2_r, fahr2_r;

  assign prod5 = 30'(na1_r) * 30'(tsse_pkg::DIV5_MUL);
  assign q5    = prod5[29:18];

  always_ff @(posedge clk) begin
    if (en.s2) begin
      m2_r    <= fahr1_r ? q5[10:0] : na1_r[10:0];
      neg2_r  <= neg1_r;
      err2_r  <= err1_r;
      fahr2_r <= fahr1_r;
    end
  end

  assign conv.err  = err2_r;
  assign conv.fahr = fahr2_r;
  assign conv.neg  = neg2_r;
  assign conv.mag  = m2_r;

endmodule

/* rtl/tsse_digits.sv */
// Digit stages: decimal split of the magnitude and display word assembly
`timescale 1ns / 1ps
module tsse_digits (
  input  logic                clk,
  input  tsse_pkg::stage_en_t en,
  input  tsse_pkg::conv_t     conv,
  output logic [29:0]         display_word,
  output logic signed [11:0]  tenths_value,
  output logic                error
);

  // stage 3: tenths digit and signed value
  logic [23:0]        prod1;
  logic [6:0]         q1_nxt, q1_r;
  logic [10:0]        m10;
  logic [3:0]         d0_r;
  logic               negv, neg3_r, big3_r, err3_r, fahr3_r;
  logic signed [11:0] mag_s;
  logic signed [11:0] tv3_r;

  assign prod1  = 24'(conv.mag) * 24'(tsse_pkg::DIV10_MUL);
  assign q1_nxt = prod1[22:16];
  assign m10    = ({4'b0, q1_nxt} << 3) + ({4'b0, q1_nxt} << 1);
  assign negv   = conv.neg && (conv.mag != 11'd0);
  assign mag_s  = $signed({1'b0, conv.mag});

  always_ff @(posedge clk) begin
    if (en.s0) begin
      q1_r    <= q1_nxt;
      d0_r    <= 4'(conv.mag - m10);
      neg3_r  <= negv;
      big3_r  <= (conv.mag >= 11'd100);
      tv3_r   <= negv ? -mag_s : mag_s;
      err3_r  <= conv.err;
      fahr3_r <= conv.fahr;
    end
  end

  // stage 4: ones, tens, hundreds
  logic [19:0]        prod2;
  logic [3:0]         q2;
  logic [6:0]         q2x10;
  logic [3:0]         d0_4_r, d1_4_r, d2_4_r;
  logic               d3_4_r, neg4_r, big4_r, err4_r, fahr4_r;
  logic signed [11:0] tv4_r;

  assign prod2 = 20'(q1_r) * 20'(tsse_pkg::DIV10_MUL);
  assign q2    = prod2[19:16];
  assign q2x10 = ({3'b0, q2} << 3) + ({3'b0, q2} << 1);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      d0_4_r  <= d0_r;
      d1_4_r  <= 4'(q1_r - q2x10);
      d3_4_r  <= (q2 >= 4'd10);
      d2_4_r  <= (q2 >= 4'd10) ? q2 - 4'd10 : q2;
      neg4_r  <= neg3_r;
      big4_r  <= big3_r;
      tv4_r   <= tv3_r;
      err4_r  <= err3_r;
      fahr4_r <= fahr3_r;
    end
  end

  // stage 5: segment lookup and slot placement
  logic [6:0]         slot2, slot3;
  logic [29:0]        word_nxt;
  logic [29:0]        word_r;
  logic signed [11:0] tv5_r;
  logic               err5_r;

  always_comb begin
    if (big4_r) begin
      slot2 = tsse_pkg::seg7(d2_4_r);
      if (neg4_r)      slot3 = tsse_pkg::MINUS_SEG;
      else if (d3_4_r) slot3 = tsse_pkg::seg7(4'd1);
      else             slot3 = 7'b0;
    end else begin
      slot2 = neg4_r ? tsse_pkg::MINUS_SEG : 7'b0;
      slot3 = 7'b0;
    end
    word_nxt = {fahr4_r, !fahr4_r, slot3, slot2,
                tsse_pkg::seg7(d1_4_r), tsse_pkg::seg7(d0_4_r)};
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      word_r <= err4_r ? 30'b0 : word_nxt;
      tv5_r  <= err4_r ? 12'sd0 : tv4_r;
      err5_r <= err4_r;
    end
  end

  assign display_word = word_r;
  assign tenths_value = tv5_r;
  assign error        = err5_r;

endmodule

/* rtl/thermometer_seven_segment_encoder_core.sv */
// Top level of the thermometer seven-segment encoder core
`timescale 1ns / 1ps
// Converts raw sensor readings (64 counts per 0.1 C, zero at -50.0 C) into
// a signed tenths-of-a-degree value and a 30-bit seven-segment display word
// (tenths, ones, tens, hundreds slots at bits 0/7/14/21, C mark at bit 28,
// F mark at bit 29). Readings above 64000 return error=1 with zero word and
// value. The core is a six-stage pipeline that takes one request per clock
// while the output side is not stalled. Every stage has its own valid bit
// and is loaded whenever it is empty or the stage after it moves, so
// bubbles are squeezed out under back-pressure and in_ready only drops
// once all six stages are full. The unit register is sampled when a
// request enters, so cfg writes belong to idle periods. Stages: range
// check and C conversion; 9c+1600 and magnitude; divide by 5; tenths
// digit; ones/tens/hundreds; segment lookup.
module thermometer_seven_segment_encoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_sensor_reading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [29:0]        out_display_word,
  output logic signed [11:0] out_tenths_value,
  output logic               out_error,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  localparam int unsigned NUM_STAGES = 6;

  // unit select, 1 = Fahrenheit
  logic unit_fahrenheit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_fahrenheit_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unit_fahrenheit_r <= cfg_wr_data;
    end
  end

  // per-stage valid bits; a stage loads when it is empty or its successor moves
  logic [NUM_STAGES-1:0] vld_r, vld_nxt, rdy, src_vld;

  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    src_vld = {vld_r[NUM_STAGES-2:0], in_valid};
    for (int i = 0; i < NUM_STAGES; i++) begin
      vld_nxt[i] = rdy[i] ? src_vld[i] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  tsse_pkg::stage_en_t en_conv, en_dig;
  tsse_pkg::conv_t     conv;

  assign en_conv.s0 = rdy[0];
  assign en_conv.s1 = rdy[1];
  assign en_conv.s2 = rdy[2];
  assign en_dig.s0  = rdy[3];
  assign en_dig.s1  = rdy[4];
  assign en_dig.s2  = rdy[5];

  tsse_convert u_convert (
    .clk     (clk),
    .en      (en_conv),
    .reading (in_sensor_reading),
    .fahr    (unit_fahrenheit_r),
    .conv    (conv)
  );

  tsse_digits u_digits (
    .clk          (clk),
    .en           (en_dig),
    .conv         (conv),
    .display_word (out_display_word),
    .tenths_value (out_tenths_value),
    .error        (out_error)
  );

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[NUM_STAGES-1];

endmodule

/* rtl/tsse_checker.sv */
// Port-level checker for the encoder core, bound to the top level
`timescale 1ns / 1ps
`include "thermometer_seven_segment_encoder_core_defines.svh"
module tsse_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [29:0]        out_display_word,
  input logic signed [11:0] out_tenths_value,
  input logic               out_error
);

  logic [42:0] out_bundle;
  logic        out_stall, out_good, tenths_in_rng;

  assign out_bundle    = {out_display_word, out_tenths_value, out_error};
  assign out_stall     = out_valid && !out_ready;
  assign out_good      = out_valid && !out_error;
  assign tenths_in_rng = (out_tenths_value >= -12'sd580) && (out_tenths_value <= 12'sd1220);

  `TSSE_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_bundle), "stalled result moved")
  `TSSE_ASSERT_NOW(a_err_zero, out_valid && out_error, out_bundle[42:1] == '0, "error word nonzero")
  `TSSE_ASSERT_NOW(a_unit_mark, out_good, ^out_display_word[29:28], "unit marks not exclusive")
  `TSSE_ASSERT_NOW(a_tenths_rng, out_good, tenths_in_rng, "tenths value out of range")

endmodule

bind thermometer_seven_segment_encoder_core tsse_checker u_tsse_checker (.*);

/* tb/tb_top.sv */
// Testbench for the thermometer seven-segment encoder core
`timescale 1ns / 1ps
module tb_top;

  // Unit register setting
  typedef enum logic {
    UNIT_CELSIUS    = 1'b0,
    UNIT_FAHRENHEIT = 1'b1
  } unit_t;

  // Expected readout of one request
  typedef struct packed {
    logic [29:0]        display;
    logic signed [11:0] tenths;
    logic               err;
  } readout_t;

  localparam int         SENSOR_OK_MAX = 64000;
  localparam logic [6:0] SEG_MINUS     = 7'b0000001;
  // Segment patterns, digit 0 in the low seven bits
  localparam logic [69:0] DIGIT_SEGS = {
    7'b1011111, 7'b1111111, 7'b0001110, 7'b1111011, 7'b1011011,
    7'b1001101, 7'b0011111, 7'b0110111, 7'b0001100, 7'b1111110
  };
  localparam int MAX_REPORTS = 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [15:0]        in_sensor_reading;
  logic               out_valid;
  logic               out_ready;
  logic [29:0]        out_display_word;
  logic signed [11:0] out_tenths_value;
  logic               out_error;
  logic               cfg_wr_en;
  logic               cfg_wr_data;

  readout_t pending_readouts[$];  // predictions waiting for their result
  unit_t    unit_sel = UNIT_CELSIUS;  // our copy of the unit register
  int       mismatch_count = 0;
  bit       no_gaps = 1'b0;         // both sides run flat out while set
  bit       readout_hold_req = 1'b0;
  int       readout_hold_left = 0;

  thermometer_seven_segment_encoder_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sensor_reading (in_sensor_reading),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_display_word  (out_display_word),
    .out_tenths_value  (out_tenths_value),
    .out_error         (out_error),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [6:0] digit_seg(input int d);
    return DIGIT_SEGS[d * 7 +: 7];
  endfunction

  // Raw reading -> tenths of a degree -> display word, for one unit setting
  function automatic readout_t convert_reading(input logic [15:0] reading, input unit_t u);
    readout_t    r;
    int          t;
    int          m;
    logic [29:0] w;
    r = '0;
    if (int'(reading) > SENSOR_OK_MAX) begin
      // out of range: word and value forced to zero
      r.err = 1'b1;
      return r;
    end
    // 64 counts per tenth, round half up on bit 5
    t = int'(reading >> 6) - 500 + int'(reading[5]);
    // SV integer division truncates toward zero, as the block must
    if (u == UNIT_FAHRENHEIT) t = (9 * t + 1600) / 5;
    m = (t < 0) ? -t : t;
    w = '0;
    w[6:0]  = digit_seg(m % 10);
    w[13:7] = digit_seg((m / 10) % 10);  // ones always lit
    if (m >= 100) begin
      w[20:14] = digit_seg((m / 100) % 10);
      if (t < 0) w[27:21] = SEG_MINUS;
      else if ((m / 1000) % 10 != 0) w[27:21] = digit_seg((m / 1000) % 10);
    end else if (t < 0) begin
      // minus moves right next to the ones digit
      w[20:14] = SEG_MINUS;
    end
    w[28] = (u == UNIT_CELSIUS);
    w[29] = (u == UNIT_FAHRENHEIT);
    r.display = w;
    r.tenths  = t[11:0];
    return r;
  endfunction

  // Reading that lands on a given Celsius tenths value, plus sub-tenth bits
  function automatic logic [15:0] celsius_reading(input int c, input logic [5:0] frac);
    return {10'(c + 500), frac};
  endfunction

  // Random reading: mostly valid range, some near the display's sign and
  // blanking edges, some near the range limit, some raw and out of range
  function automatic logic [15:0] pick_reading();
    int roll;
    int c;
    roll = $urandom_range(99);
    if (roll < 60) return 16'($urandom_range(SENSOR_OK_MAX));
    if (unit_sel == UNIT_FAHRENHEIT) c = int'($urandom_range(180)) - 240;
    else c = int'($urandom_range(240)) - 120;
    if (roll < 75) return celsius_reading(c, 6'($urandom));
    if (roll < 80) return 16'($urandom_range(SENSOR_OK_MAX + 10, SENSOR_OK_MAX - 10));
    if (roll < 90) return 16'($urandom);
    return 16'($urandom_range(65535, SENSOR_OK_MAX + 1));
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Offer one request; prediction is queued at the accepting edge
  task automatic offer_reading(input logic [15:0] reading);
    if (!no_gaps && $urandom_range(99) < 13) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_sensor_reading <= reading;
    do @(posedge clk); while (!in_ready);
    pending_readouts.push_back(convert_reading(reading, unit_sel));
  endtask

  // Stop offering and wait until every predicted result has come back.
  // Every request yields a result, so an empty queue means an empty pipe.
  task automatic wait_readouts_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
  endtask

  task automatic write_unit(input unit_t u);
    wait_readouts_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= u;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    unit_sel = u;
  endtask

  // Result side: random stalls, flat-out stretches, and long hold-offs
  // counted down here once a test asks for one
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (readout_hold_req) begin
        readout_hold_left = 60;
        readout_hold_req  = 1'b0;
      end
      if (readout_hold_left > 0) begin
        out_ready <= 1'b0;
        readout_hold_left--;
      end else if (no_gaps) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 13);
      end
    end
  end

  // Result checker: every accepted result against the oldest prediction
  always @(posedge clk) begin
    readout_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_readouts.size() == 0) begin
        report_mismatch($sformatf("unexpected result word=%h value=%0d err=%b",
                                  out_display_word, out_tenths_value, out_error));
      end else begin
        want = pending_readouts.pop_front();
        if (out_display_word !== want.display)
          report_mismatch($sformatf("display_word got %h want %h",
                                    out_display_word, want.display));
        if (out_tenths_value !== want.tenths)
          report_mismatch($sformatf("tenths_value got %0d want %0d",
                                    out_tenths_value, want.tenths));
        if (out_error !== want.err)
          report_mismatch($sformatf("error got %b want %b", out_error, want.err));
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Celsius: range ends, half-up rounding, sign placement and blanking
  task automatic test_celsius_directed();
    write_unit(UNIT_CELSIUS);
    offer_reading(16'd0);                        // -50.0
    offer_reading(16'd32);                       // rounds up to -49.9
    offer_reading(celsius_reading(-100, 6'd0));  // minus in top slot
    offer_reading(celsius_reading(-99, 6'd0));   // minus next to ones
    offer_reading(celsius_reading(-1, 6'h20));   // rounds up to zero
    offer_reading(celsius_reading(-5, 6'd0));
    offer_reading(celsius_reading(0, 6'h1F));    // just below rounding
    offer_reading(celsius_reading(99, 6'd0));    // tens still blank
    offer_reading(celsius_reading(100, 6'd0));   // tens lit
    wait_readouts_drained();
  endtask

  // Fahrenheit: negative truncation toward zero and the thousands slot
  task automatic test_fahrenheit_directed();
    write_unit(UNIT_FAHRENHEIT);
    offer_reading(16'd0);                          // -58.0 F
    offer_reading(celsius_reading(-178, 6'd0));    // -0.4 truncates to 0
    offer_reading(celsius_reading(-179, 6'd0));    // -2.2 truncates to -2
    offer_reading(celsius_reading(-189, 6'd0));    // short negative
    offer_reading(celsius_reading(-201, 6'd0));
    offer_reading(celsius_reading(-170, 6'd0));    // small positive
    offer_reading(celsius_reading(0, 6'd0));       // 32.0 F, top slot blank
    offer_reading(16'd64000);                      // 122.0 F, top slot lit
    wait_readouts_drained();
  endtask

  // Range limit in both units
  task automatic test_out_of_range();
    offer_reading(16'd64001);
    offer_reading(16'hFFFF);
    write_unit(UNIT_CELSIUS);
    offer_reading(16'd64000);
    offer_reading(16'd64001);
    offer_reading(16'hFFFF);
    wait_readouts_drained();
  endtask

  // Result side held off while requests keep coming: pipe fills, input stalls
  task automatic test_backpressure();
    int i;
    wait_readouts_drained();
    @(posedge clk);
    readout_hold_req = 1'b1;
    no_gaps = 1'b1;
    for (i = 0; i < 40; i++) offer_reading(pick_reading());
    no_gaps = 1'b0;
    wait_readouts_drained();
  endtask

  // Random phases, unit flipping between them, one phase without gaps
  task automatic test_random_readings(input int total);
    int p;
    int i;
    for (p = 0; p < 5; p++) begin
      write_unit(unit_t'(p[0]));
      no_gaps = (p == 2);
      for (i = 0; i < total / 5; i++) offer_reading(pick_reading());
    end
    no_gaps = 1'b0;
    wait_readouts_drained();
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_sensor_reading = '0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_celsius_directed();
    test_fahrenheit_directed();
    test_out_of_range();
    test_backpressure();
    test_random_readings(1150);

    // let any stray result surface before the verdict
    wait_readouts_drained();
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule
